// ----- rtl/bta_pkg.sv -----
package bta_pkg;

  // Command codes; the unused code 3 behaves as a query
  typedef enum logic [1:0] {
    CMD_TAKE    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HELD     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Datapath operation selected by the current microcode step
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_FINISH = 2'd3
  } dp_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_NO_START = 2'd0,
    C_MORE     = 2'd1,
    C_NEVER    = 2'd2,
    C_ALWAYS   = 2'd3
  } cond_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_SCAN   = 2'd1;
  localparam step_t STEP_DRAIN  = 2'd2;
  localparam step_t STEP_FINISH = 2'd3;

  // One control word: what the datapath does, and where to go next
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } uop_t;

  localparam int UCODE_DEPTH = 4;

  // Program: wait for start, scan the store, drain the read, finish
  localparam uop_t UCODE [UCODE_DEPTH] = '{
    '{op: OP_LOAD,   cond: C_NO_START, target: STEP_IDLE},
    '{op: OP_READ,   cond: C_MORE,     target: STEP_SCAN},
    '{op: OP_DRAIN,  cond: C_NEVER,    target: STEP_IDLE},
    '{op: OP_FINISH, cond: C_ALWAYS,   target: STEP_IDLE}
  };

  // Sequencer condition inputs
  typedef struct packed {
    logic start;
    logic more;
  } seq_cond_t;

  // Sequencer outputs to the datapath
  typedef struct packed {
    dp_op_t op;
    logic   busy;
  } seq_ctrl_t;

endpackage

// ----- rtl/bta_seq.sv -----
module bta_seq (
  input  logic               clk,
  input  logic               rst,
  input  bta_pkg::seq_cond_t cond_in,
  output bta_pkg::seq_ctrl_t ctrl
);
  import bta_pkg::*;

  step_t step;
  step_t step_next;
  uop_t  uop;
  logic  jump;

  assign uop = UCODE[step];

  // Jump condition decode
  always_comb begin
    unique case (uop.cond)
      C_NO_START: jump = !cond_in.start;
      C_MORE:     jump = cond_in.more;
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      default:    jump = 1'b1;
    endcase
    step_next = jump ? uop.target : step + 2'd1;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op   = uop.op;
  assign ctrl.busy = (step != STEP_IDLE);

endmodule

// ----- rtl/bakery_ticket_arbiter.sv -----
// Bakery-style ticket arbiter. Each requester owns one ticket; take hands out
// one above the largest active ticket, release clears it, query only reports.
// An item is accepted when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with strobe high, and must be
// taken then, since the block cannot be held off. Busy stays high from the
// accepting edge until the result is registered, so no new item is taken
// before the last one is through: the microcoded scan reads one ticket per
// cycle through the single read port of the ticket store, over active_count
// entries saturated to NUM_REQUESTERS, then a drain step waits for the
// registered read and a finish step updates the store and forms the result.
// The next item can be accepted in the cycle the result is shown. The store
// is cleared at reset through per-entry valid bits, so there is no clearing
// pass.
module bakery_ticket_arbiter #(
  parameter int NUM_REQUESTERS = 16,
  parameter int TICKET_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [3:0]  requester,
  // result channel
  output logic        strobe,
  output logic [1:0]  status,
  output logic [15:0] ticket,
  output logic        head_valid,
  output logic [3:0]  head_index,
  output logic        requester_is_head,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bta_pkg::*;

  localparam int AW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam logic [8:0] NREQ = 9'(NUM_REQUESTERS);

  typedef logic [TICKET_BITS-1:0] tkt_t;

  seq_cond_t seq_cond;
  seq_ctrl_t ctrl;

  logic [4:0] active_count;
  logic [4:0] n_eff;

  // latched item
  logic [1:0] cmd_q;
  logic [4:0] req_q;

  // scan state
  logic [4:0] k;
  logic       rd_pend;
  logic [4:0] rd_idx;
  tkt_t       mem_q;
  logic       vld_q;
  tkt_t       rdata;
  tkt_t       maxv;
  tkt_t       req_old;
  logic       bv;
  tkt_t       bval;
  logic [4:0] bidx;

  // ticket store
  tkt_t                      mem [NUM_REQUESTERS];
  logic [NUM_REQUESTERS-1:0] valid;

  // finish stage
  logic       in_range;
  status_t    st;
  logic       wr_en;
  tkt_t       new_t;
  logic       req_wins;
  logic       hv;
  logic [4:0] hidx;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (!paddr[2]) ? {27'd0, active_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= 5'd16;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      active_count <= pwdata[4:0];
    end
  end

  assign n_eff = (9'(active_count) > NREQ) ? NREQ[4:0] : active_count;

  // ---------------- sequencer ----------------
  assign seq_cond.start = start;
  assign seq_cond.more  = ({1'b0, k} + 6'd1) < {1'b0, n_eff};

  bta_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cond_in (seq_cond),
    .ctrl    (ctrl)
  );

  assign busy = ctrl.busy;

  // ---------------- finish logic ----------------
  assign in_range = req_q < n_eff;

  always_comb begin
    st    = ST_OK;
    wr_en = 1'b0;
    new_t = req_old;
    unique case (cmd_q)
      CMD_TAKE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else if (req_old != '0) begin
          st = ST_HELD;
        end else if (&maxv) begin
          st = ST_OVERFLOW;
        end else begin
          wr_en = 1'b1;
          new_t = maxv + tkt_t'(1);
        end
      end
      CMD_RELEASE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          wr_en = 1'b1;
          new_t = '0;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // merge the requester's new ticket with the best of the other entries
  always_comb begin
    req_wins = in_range && (new_t != '0) &&
               (!bv || (new_t < bval) || ((new_t == bval) && (req_q < bidx)));
    hv       = bv || req_wins;
    hidx     = req_wins ? req_q : bidx;
  end

  // ---------------- store: read and write ports ----------------
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_READ) begin
      mem_q <= mem[AW'(k)];
      vld_q <= valid[AW'(k)];
    end
    if (ctrl.op == OP_FINISH && wr_en) begin
      mem[AW'(req_q)] <= new_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.op == OP_FINISH && wr_en) begin
      valid[AW'(req_q)] <= 1'b1;
    end
  end

  assign rdata = vld_q ? mem_q : '0;

  // ---------------- scan control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      k       <= '0;
    end else begin
      rd_pend <= 1'b0;
      unique case (ctrl.op)
        OP_LOAD: begin
          k <= '0;
        end
        OP_READ: begin
          if (k < n_eff) begin
            rd_pend <= 1'b1;
            rd_idx  <= k;
            k       <= k + 5'd1;
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // ---------------- item latch and accumulators ----------------
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LOAD && start) begin
      cmd_q   <= cmd;
      req_q   <= {1'b0, requester};
      maxv    <= '0;
      req_old <= '0;
      bv      <= 1'b0;
      bval    <= '0;
      bidx    <= '0;
    end else if (rd_pend) begin
      if (rdata > maxv) begin
        maxv <= rdata;
      end
      if (rd_idx == req_q) begin
        req_old <= rdata;
      end else if ((rdata != '0) && (!bv || (rdata < bval))) begin
        bv   <= 1'b1;
        bval <= rdata;
        bidx <= rd_idx;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (ctrl.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FINISH) begin
      status            <= st;
      ticket            <= in_range ? 16'(new_t) : 16'd0;
      head_valid        <= hv;
      head_index        <= hidx[3:0];
      requester_is_head <= hv && in_range && (hidx == req_q);
    end
  end

endmodule

// ----- rtl/bta_checker.sv -----
module bta_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [1:0]  status,
  input logic [15:0] ticket,
  input logic        head_valid,
  input logic [3:0]  head_index,
  input logic        requester_is_head
);
  import bta_pkg::*;

  // an accepted item makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows a cycle of work
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result without preceding work");

  // no head: head index is zero and the requester cannot be head
  a_no_head: assert property (@(posedge clk) disable iff (rst)
    (strobe && !head_valid) |-> (head_index == 4'd0) && !requester_is_head)
    else $error("head fields set without a head");

  // out-of-range requester has no ticket and is never head
  a_range: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_RANGE)) |-> (ticket == 16'd0) && !requester_is_head)
    else $error("out-of-range item reports a ticket or head");

endmodule

bind bakery_ticket_arbiter bta_checker u_bta_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .strobe            (strobe),
  .status            (status),
  .ticket            (ticket),
  .head_valid        (head_valid),
  .head_index        (head_index),
  .requester_is_head (requester_is_head)
);

// ----- sim/bakery_ticket_arbiter_checker.sv -----
`timescale 1ns / 100ps

// Watches the command, result and register channels of the ticket arbiter,
// keeps its own ticket store and compares every result with the prediction.
module bakery_ticket_arbiter_checker
  import bta_pkg::*;
#(
  parameter logic [2:0] ACTIVE_COUNT_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd,
  input  logic [3:0]  requester,
  input  logic        strobe,
  input  logic [1:0]  status,
  input  logic [15:0] ticket,
  input  logic        head_valid,
  input  logic [3:0]  head_index,
  input  logic        requester_is_head,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  localparam int NUM_SLOTS = 16;
  localparam int TICKET_W  = 16;

  typedef struct packed {
    status_t             status;
    logic [TICKET_W-1:0] ticket;
    logic                head_valid;
    logic [3:0]          head_index;
    logic                requester_is_head;
  } arb_result_t;

  logic [TICKET_W-1:0] ticket_store [NUM_SLOTS];
  logic [4:0]          active_count;
  arb_result_t         owed_results [$];
  int                  error_count = 0;

  assign mismatches = error_count;

  // Apply one command to the store and form the result it produces
  function automatic arb_result_t apply_command(input logic [1:0] op, input logic [3:0] who);
    int                  live;
    logic                in_range;
    logic [TICKET_W-1:0] top_ticket;
    logic [TICKET_W-1:0] head_ticket;
    arb_result_t         res;
    live        = (active_count > 5'd16) ? NUM_SLOTS : int'(active_count);
    in_range    = int'(who) < live;
    top_ticket  = '0;
    head_ticket = '0;
    res         = '0;
    res.status  = ST_OK;
    for (int k = 0; k < live; k++)
      if (ticket_store[k] > top_ticket) top_ticket = ticket_store[k];

    case (op)
      CMD_TAKE: begin
        if (!in_range) res.status = ST_RANGE;
        else if (ticket_store[who] != '0) res.status = ST_HELD;
        else if (&top_ticket) res.status = ST_OVERFLOW;  // next ticket would not fit
        else ticket_store[who] = top_ticket + 1'b1;
      end
      CMD_RELEASE: begin
        if (!in_range) res.status = ST_RANGE;
        else ticket_store[who] = '0;
      end
      default: ;  // query, and the unused code acts as one
    endcase

    // head: lowest nonzero ticket, first index wins a tie
    for (int k = 0; k < live; k++) begin
      if (ticket_store[k] != '0 && (!res.head_valid || ticket_store[k] < head_ticket)) begin
        res.head_valid = 1'b1;
        head_ticket    = ticket_store[k];
        res.head_index = 4'(k);
      end
    end

    if (in_range) res.ticket = ticket_store[who];
    res.requester_is_head = res.head_valid && in_range && res.head_index == who;
    return res;
  endfunction

  task automatic report(input string what, input arb_result_t want, input arb_result_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t ns: %s: expected st=%0d tkt=%0d hv=%0d hd=%0d me=%0d, got st=%0d tkt=%0d hv=%0d hd=%0d me=%0d",
               $time, what, want.status, want.ticket, want.head_valid, want.head_index,
               want.requester_is_head, got.status, got.ticket, got.head_valid,
               got.head_index, got.requester_is_head);
  endtask

  // Register writes, results and accepted items, in that order per edge
  always @(posedge clk) begin : watch
    arb_result_t want;
    arb_result_t got;
    if (rst) begin
      foreach (ticket_store[k]) ticket_store[k] = '0;
      active_count = 5'd16;
      owed_results.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ACTIVE_COUNT_ADDR)
        active_count = pwdata[4:0];

      if (strobe) begin
        got.status            = status_t'(status);
        got.ticket            = ticket;
        got.head_valid        = head_valid;
        got.head_index        = head_index;
        got.requester_is_head = requester_is_head;
        if (owed_results.size() == 0) begin
          report("result with no item waiting", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) report("result mismatch", want, got);
        end
      end

      if (start && !busy) owed_results.push_back(apply_command(cmd, requester));
      outstanding <= owed_results.size();
    end
  end

endmodule

// ----- sim/bakery_ticket_arbiter_tb.sv -----
`timescale 1ns / 100ps

module bakery_ticket_arbiter_tb;
  import bta_pkg::*;

  localparam logic [2:0] ACTIVE_COUNT_ADDR = 3'd0;
  localparam logic [1:0] CMD_UNUSED        = 2'd3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [3:0]  requester;
  logic        strobe;
  logic [1:0]  status;
  logic [15:0] ticket;
  logic        head_valid;
  logic [3:0]  head_index;
  logic        requester_is_head;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic [4:0]  live_setting;
  int          mismatches;
  int          outstanding;

  bakery_ticket_arbiter i_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cmd               (cmd),
    .requester         (requester),
    .strobe            (strobe),
    .status            (status),
    .ticket            (ticket),
    .head_valid        (head_valid),
    .head_index        (head_index),
    .requester_is_head (requester_is_head),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  bakery_ticket_arbiter_checker #(
    .ACTIVE_COUNT_ADDR (ACTIVE_COUNT_ADDR)
  ) i_checker (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cmd               (cmd),
    .requester         (requester),
    .strobe            (strobe),
    .status            (status),
    .ticket            (ticket),
    .head_valid        (head_valid),
    .head_index        (head_index),
    .requester_is_head (requester_is_head),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("** bakery_ticket_arbiter: FAILED **");
    $finish;
  end

  // Present one item; the gap is counted from the last accept, or from the
  // block going idle when after_idle is set. Returns at the accepting edge.
  task automatic send_item(input logic [1:0] op, input logic [3:0] who,
                           input int gap, input bit after_idle);
    if (after_idle || gap > 0) start <= 1'b0;
    if (after_idle) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    start     <= 1'b1;
    cmd       <= op;
    requester <= who;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_with_gap(input logic [1:0] op, input logic [3:0] who);
    send_item(op, who, $urandom_range(0, 7), 1'($urandom_range(0, 1)));
  endtask

  // Hold off until every item has produced its result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_active_count(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_COUNT_ADDR;
    pwdata  <= {27'($urandom() >> 5), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    live_setting = value;
  endtask

  // Mostly requesters that take part, sometimes any index
  function automatic logic [3:0] pick_requester();
    int live;
    live = (live_setting > 5'd16) ? 16 : int'(live_setting);
    if (live > 0 && $urandom_range(0, 4) != 0) return 4'($urandom_range(0, live - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [1:0] pick_command();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return CMD_TAKE;
    if (roll < 7) return CMD_RELEASE;
    if (roll < 9) return CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  initial begin
    logic [4:0] phase_setting [8];
    int         phase_items;
    bit         no_gaps;
    int         waited;

    rst          = 1'b1;
    start        = 1'b0;
    cmd          = CMD_QUERY;
    requester    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    live_setting = 5'd16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, idle release, refusals, head moves, ignored entries
    write_active_count(5'd16);
    send_with_gap(CMD_QUERY,   4'd0);
    send_with_gap(CMD_RELEASE, 4'd3);
    send_with_gap(CMD_TAKE,    4'd0);
    send_with_gap(CMD_TAKE,    4'd15);
    send_with_gap(CMD_TAKE,    4'd0);
    send_with_gap(CMD_TAKE,    4'd7);
    send_with_gap(CMD_RELEASE, 4'd0);
    send_with_gap(CMD_UNUSED,  4'd15);
    send_with_gap(CMD_TAKE,    4'd0);
    send_with_gap(CMD_RELEASE, 4'd15);
    send_with_gap(CMD_QUERY,   4'd7);
    settle();
    write_active_count(5'd4);
    send_with_gap(CMD_TAKE,    4'd9);
    send_with_gap(CMD_RELEASE, 4'd12);
    send_with_gap(CMD_QUERY,   4'd15);
    send_with_gap(CMD_TAKE,    4'd3);
    settle();
    write_active_count(5'd0);
    send_with_gap(CMD_TAKE,    4'd0);
    send_with_gap(CMD_QUERY,   4'd0);
    settle();
    write_active_count(5'd31);
    send_with_gap(CMD_TAKE,    4'd15);
    send_with_gap(CMD_QUERY,   4'd7);
    send_with_gap(CMD_RELEASE, 4'd7);
    send_with_gap(CMD_RELEASE, 4'd0);
    send_with_gap(CMD_RELEASE, 4'd3);
    send_with_gap(CMD_RELEASE, 4'd15);

    // Random phases, one count setting each
    phase_setting = '{5'd1, 5'd31, 5'd2, 5'd0, 5'($urandom_range(3, 15)), 5'd5, 5'd16,
                      5'($urandom_range(1, 16))};
    for (int p = 0; p < 8; p++) begin
      settle();
      write_active_count(phase_setting[p]);
      phase_items = (phase_setting[p] == 5'd0) ? 20 : 55;
      no_gaps     = (p == 1 || p == 5 || $urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_items; i++) begin
        if (p == 3 && i == phase_items / 2) settle();
        if (no_gaps) send_item(pick_command(), pick_requester(), 0, 1'b0);
        else send_with_gap(pick_command(), pick_requester());
      end
    end

    // Drain, then allow time for any stray result
    start <= 1'b0;
    @(posedge clk);
    for (waited = 0; waited < 1000 && outstanding != 0; waited++) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("** bakery_ticket_arbiter: PASSED **");
    end else begin
      $display("** bakery_ticket_arbiter: FAILED **");
    end
    $finish;
  end

endmodule
